@@ hdl/lpu_pkg.sv @@
// Shared types, constants and helper functions for the LCD palette pixel unpacker.
// Holds the 4-bit expansion tables, the palette entry widening and frame sizing.
// No dependencies; the unit and the testbench refer to it by scoped names.
package lpu_pkg;

    // Sizes of the palette store and the screen
    localparam int PALETTE_ENTRIES = 256;
    localparam int MAX_DIM         = 1024;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int IDX_W           = 8;
    localparam int PIDX_W          = 9;
    localparam int DEPTH_W         = 3;
    localparam int LEFT_W          = 4;
    localparam int WORD_W          = 16;
    localparam int CFG_DIM_W       = 10;
    localparam int DIM_W           = $clog2(MAX_DIM) + 1;
    localparam int AREA_W          = 2 * DIM_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CFG_DIM_W;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_ONLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd3;

    // Pixel depth codes from bits 14:12 of the first palette word
    localparam logic [DEPTH_W-1:0] DEPTH_1BPP = 3'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_2BPP = 3'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_4BPP = 3'd2;
    localparam logic [DEPTH_W-1:0] DEPTH_8BPP = 3'd3;

    // Palette lengths
    localparam logic [PIDX_W-1:0] PAL_LEN_SHORT = 9'd16;
    localparam logic [PIDX_W-1:0] PAL_LEN_FULL  = PIDX_W'(PALETTE_ENTRIES);

    typedef enum logic {
        PH_PALETTE = 1'b0,
        PH_DATA    = 1'b1
    } phase_t;

    // Expansion tables, 4-bit level to 6-bit and 5-bit channel
    localparam logic [5:0] MONO6 [16] = '{6'd63, 6'd58, 6'd54, 6'd49, 6'd45, 6'd40, 6'd36,
        6'd31, 6'd27, 6'd22, 6'd18, 6'd13, 6'd9, 6'd4, 6'd0, 6'd0};
    localparam logic [4:0] MONO5 [16] = '{5'd31, 5'd29, 5'd27, 5'd24, 5'd22, 5'd20, 5'd18,
        5'd15, 5'd13, 5'd11, 5'd9, 5'd7, 5'd4, 5'd2, 5'd0, 5'd0};
    localparam logic [5:0] COL6 [16] = '{6'd0, 6'd4, 6'd8, 6'd13, 6'd17, 6'd21, 6'd25,
        6'd29, 6'd34, 6'd38, 6'd42, 6'd46, 6'd50, 6'd55, 6'd59, 6'd63};
    localparam logic [4:0] COL5 [16] = '{5'd0, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12,
        5'd14, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd29, 5'd31};

    // Widen one palette word to RGB565
    function automatic logic [WORD_W-1:0] expand_entry(input logic mono,
                                                       input logic [WORD_W-1:0] v);
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
        if (mono) begin
            r = MONO5[v[3:0]];
            g = MONO6[v[3:0]];
            b = r;
        end else begin
            r = COL5[v[11:8]];
            g = COL6[v[7:4]];
            b = COL5[v[3:0]];
        end
        return {r, g, b};
    endfunction

    // Screen dimension from its minus-one register, clamped to MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] m1);
        logic [CFG_DIM_W:0] d;
        d = {1'b0, m1} + (CFG_DIM_W+1)'(1);
        if (int'(d) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(d);
    endfunction

    // Data words per frame from the pixel count and the depth
    function automatic logic [AREA_W-1:0] frame_words(input logic [AREA_W-1:0] area,
                                                      input logic [DEPTH_W-1:0] depth);
        logic [AREA_W-1:0] n;
        n = area;
        if (depth <= DEPTH_8BPP) begin
            n = area >> (3'd4 - depth);
        end
        if (n == '0) begin
            n = AREA_W'(1);
        end
        return n;
    endfunction

endpackage

@@ hdl/lpu_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// A read at the address being written returns the old contents.
// No dependencies.
module lpu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read, read returns pre-write data
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/lcd_palette_pixel_unpacker_unit.sv @@
// Top level of the LCD palette pixel unpacker: frame sequencing, unpack stage,
// palette memory read pipeline and output register.
// Depends on lpu_pkg and lpu_ram.
//
// Usage:
// - s_valid/s_ready/s_fetched_word carries the frame words in fetch order.
//   Palette words are stored and yield no pixel; data words yield 16, 8, 4
//   or 2 pixels at 1, 2, 4 or 8 bpp, and one pass-through pixel otherwise.
// - m_valid/m_ready carries one RGB565 pixel per transfer with
//   m_last_of_word and m_frame_done flags.
// - cfg_valid/cfg_ready/cfg_index/cfg_data writes the four registers
//   (data only, mono palette, width minus one, height minus one); write them
//   only while the block is idle. cfg_ready is always high.
// - The first pixel of a data word passes the unpack stage, the memory read
//   stage and the output register. Throughput: one pixel per cycle while the
//   receiver is ready, set by the single read port of the palette memory.
// - Reset sets the control and configuration registers and clears the palette valid bits (unwritten entries
//   read as zero); the block opens in palette phase.
// - A stalled receiver holds the output register, then the memory read stage,
//   then the unpack stage; a new word, palette or data, is taken as the unpack
//   stage issues the last pixel of the previous data word.
module lcd_palette_pixel_unpacker_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [15:0]                        s_fetched_word,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [15:0]                        m_pixel,
    output logic                               m_last_of_word,
    output logic                               m_frame_done,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lpu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lpu_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers
    logic                              data_only_reg;
    logic                              mono_reg;
    logic [lpu_pkg::CFG_DIM_W-1:0]     wm1_reg;
    logic [lpu_pkg::CFG_DIM_W-1:0]     hm1_reg;
    logic [lpu_pkg::AREA_W-1:0]        area_reg;
    logic [lpu_pkg::AREA_W-1:0]        area_next;

    // Frame sequencing state
    lpu_pkg::phase_t                   phase_reg, phase_next;
    logic [lpu_pkg::PIDX_W-1:0]        pal_idx_reg, pal_idx_next;
    logic [lpu_pkg::PIDX_W-1:0]        pal_len_reg, pal_len_next;
    logic [lpu_pkg::DEPTH_W-1:0]       depth_reg, depth_next;
    logic [lpu_pkg::AREA_W-1:0]        wc_reg, wc_next;
    logic [lpu_pkg::PALETTE_ENTRIES-1:0] pal_ok_reg;

    // Unpack stage
    logic                              a_valid_reg;
    logic [15:0]                       a_shift_reg;
    logic [lpu_pkg::DEPTH_W-1:0]       a_depth_reg;
    logic [lpu_pkg::LEFT_W-1:0]        a_left_reg;
    logic                              a_pass_reg;
    logic                              a_last_reg;

    // Memory read stage
    logic                              b_valid_reg;
    logic                              b_pass_reg;
    logic [15:0]                       b_word_reg;
    logic                              b_ok_reg;
    logic                              b_low_reg;
    logic                              b_done_reg;

    // Output register
    logic                              c_valid_reg;
    logic [15:0]                       c_pixel_reg;
    logic                              c_low_reg;
    logic                              c_done_reg;

    // Handshake and pipeline control
    logic                              cfg_fire;
    logic                              in_fire;
    logic                              pal_fire;
    logic                              data_fire;
    logic                              c_free;
    logic                              b_move;
    logic                              b_free;
    logic                              issue;
    logic                              a_done;
    logic                              a_free;
    logic                              at_start;
    logic                              last_word;
    logic [lpu_pkg::PIDX_W-1:0]        pal_idx_inc;
    logic [lpu_pkg::AREA_W-1:0]        words;
    logic [lpu_pkg::DEPTH_W-1:0]       new_depth;

    // Unpack datapath
    logic [lpu_pkg::IDX_W-1:0]         rd_idx;
    logic [15:0]                       shift_adv;
    logic                              rd_in_range;
    logic [lpu_pkg::LEFT_W-1:0]        load_left;
    logic                              load_pass;

    // Palette memory ports
    logic                              ram_we;
    logic [lpu_pkg::PAL_AW-1:0]        ram_waddr;
    logic [15:0]                       ram_wdata;
    logic [lpu_pkg::PAL_AW-1:0]        ram_raddr;
    logic [15:0]                       ram_rdata;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = s_valid && s_ready;
    assign pal_fire  = in_fire && (phase_reg == lpu_pkg::PH_PALETTE);
    assign data_fire = in_fire && (phase_reg == lpu_pkg::PH_DATA);

    // Pipeline flow, output side first
    assign c_free = !c_valid_reg || m_ready;
    assign b_move = b_valid_reg && c_free;
    assign b_free = !b_valid_reg || b_move;
    assign issue  = a_valid_reg && b_free;
    assign a_done = issue && (a_left_reg == '0);
    assign a_free = !a_valid_reg || a_done;

    // Outputs of the frame sequencer: hold palette words too until the last
    // read of the previous data word has issued, so no entry changes under it
    always_comb begin
        s_ready = a_free;
    end

    // Next state of the frame sequencer
    always_comb begin
        phase_next   = phase_reg;
        pal_idx_next = pal_idx_reg;
        pal_len_next = pal_len_reg;
        depth_next   = depth_reg;
        wc_next      = wc_reg;
        new_depth    = s_fetched_word[14:12];
        pal_idx_inc  = pal_idx_reg + lpu_pkg::PIDX_W'(1);
        words        = lpu_pkg::frame_words(area_reg, depth_reg);
        last_word    = ({1'b0, wc_reg} + (lpu_pkg::AREA_W+1)'(1)) >= {1'b0, words};
        at_start     = (phase_reg == lpu_pkg::PH_PALETTE) ? (pal_idx_reg == '0)
                                                          : (wc_reg == '0);
        if (pal_fire) begin
            // First palette word sets the depth and the palette length
            if (pal_idx_reg == '0) begin
                depth_next   = new_depth;
                pal_len_next = (new_depth == lpu_pkg::DEPTH_8BPP) ? lpu_pkg::PAL_LEN_FULL
                                                                  : lpu_pkg::PAL_LEN_SHORT;
            end
            pal_idx_next = pal_idx_inc;
            if (pal_idx_inc >= pal_len_next) begin
                phase_next   = lpu_pkg::PH_DATA;
                pal_idx_next = '0;
                wc_next      = '0;
            end
        end else if (data_fire) begin
            // Count data words; restart at the end of the frame
            if (last_word) begin
                phase_next   = data_only_reg ? lpu_pkg::PH_DATA : lpu_pkg::PH_PALETTE;
                pal_idx_next = '0;
                wc_next      = '0;
            end else begin
                wc_next = wc_reg + lpu_pkg::AREA_W'(1);
            end
        end
        // Mode change restarts a frame that has not begun
        if (cfg_fire && (cfg_index == lpu_pkg::CFG_DATA_ONLY) && at_start) begin
            phase_next   = cfg_data[0] ? lpu_pkg::PH_DATA : lpu_pkg::PH_PALETTE;
            pal_idx_next = '0;
            wc_next      = '0;
        end
    end

    // Recompute pixel count on a dimension write
    always_comb begin
        area_next = area_reg;
        if (cfg_fire && (cfg_index == lpu_pkg::CFG_WIDTH)) begin
            area_next = lpu_pkg::AREA_W'(lpu_pkg::clamp_dim(cfg_data)) *
                        lpu_pkg::AREA_W'(lpu_pkg::clamp_dim(hm1_reg));
        end else if (cfg_fire && (cfg_index == lpu_pkg::CFG_HEIGHT)) begin
            area_next = lpu_pkg::AREA_W'(lpu_pkg::clamp_dim(wm1_reg)) *
                        lpu_pkg::AREA_W'(lpu_pkg::clamp_dim(cfg_data));
        end
    end

    // Configuration and sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_only_reg <= 1'b0;
            mono_reg      <= 1'b0;
            wm1_reg       <= '0;
            hm1_reg       <= '0;
            area_reg      <= lpu_pkg::AREA_W'(1);
            phase_reg     <= lpu_pkg::PH_PALETTE;
            pal_idx_reg   <= '0;
            pal_len_reg   <= lpu_pkg::PAL_LEN_SHORT;
            depth_reg     <= lpu_pkg::DEPTH_1BPP;
            wc_reg        <= '0;
        end else begin
            if (cfg_fire) begin
                unique case (cfg_index)
                    lpu_pkg::CFG_DATA_ONLY: data_only_reg <= cfg_data[0];
                    lpu_pkg::CFG_MONO:      mono_reg      <= cfg_data[0];
                    lpu_pkg::CFG_WIDTH:     wm1_reg       <= cfg_data;
                    lpu_pkg::CFG_HEIGHT:    hm1_reg       <= cfg_data;
                    default:                ;
                endcase
            end
            area_reg    <= area_next;
            phase_reg   <= phase_next;
            pal_idx_reg <= pal_idx_next;
            pal_len_reg <= pal_len_next;
            depth_reg   <= depth_next;
            wc_reg      <= wc_next;
        end
    end

    // Palette write from the incoming word
    assign ram_we    = pal_fire && (pal_idx_reg < lpu_pkg::PAL_LEN_FULL);
    assign ram_waddr = pal_idx_reg[lpu_pkg::PAL_AW-1:0];
    assign ram_wdata = lpu_pkg::expand_entry(mono_reg, s_fetched_word);

    // Mark written palette entries
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pal_ok_reg <= '0;
        end else if (ram_we) begin
            pal_ok_reg[ram_waddr] <= 1'b1;
        end
    end

    // Pixels per word and pass-through for the depth of the new word
    always_comb begin
        load_pass = 1'b0;
        unique case (depth_reg)
            lpu_pkg::DEPTH_1BPP: load_left = lpu_pkg::LEFT_W'(15);
            lpu_pkg::DEPTH_2BPP: load_left = lpu_pkg::LEFT_W'(7);
            lpu_pkg::DEPTH_4BPP: load_left = lpu_pkg::LEFT_W'(3);
            lpu_pkg::DEPTH_8BPP: load_left = lpu_pkg::LEFT_W'(1);
            default: begin
                load_left = '0;
                load_pass = 1'b1;
            end
        endcase
    end

    // Select the next palette index, MSB first, and advance the shifter
    always_comb begin
        unique case (a_depth_reg)
            lpu_pkg::DEPTH_1BPP: begin
                rd_idx    = lpu_pkg::IDX_W'(a_shift_reg[15]);
                shift_adv = {a_shift_reg[14:0], 1'b0};
            end
            lpu_pkg::DEPTH_2BPP: begin
                rd_idx    = lpu_pkg::IDX_W'(a_shift_reg[15:14]);
                shift_adv = {a_shift_reg[13:0], 2'b0};
            end
            lpu_pkg::DEPTH_4BPP: begin
                rd_idx    = lpu_pkg::IDX_W'(a_shift_reg[15:12]);
                shift_adv = {a_shift_reg[11:0], 4'b0};
            end
            lpu_pkg::DEPTH_8BPP: begin
                rd_idx    = a_shift_reg[15:8];
                shift_adv = {a_shift_reg[7:0], 8'b0};
            end
            default: begin
                rd_idx    = '0;
                shift_adv = a_shift_reg;
            end
        endcase
        rd_in_range = {1'b0, rd_idx} < lpu_pkg::PAL_LEN_FULL;
        ram_raddr   = rd_idx[lpu_pkg::PAL_AW-1:0];
    end

    // Unpack stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (data_fire) begin
            a_valid_reg <= 1'b1;
        end else if (a_done) begin
            a_valid_reg <= 1'b0;
        end
    end

    // Unpack stage payload: load byte-swapped word, shift per issued pixel
    always_ff @(posedge aclk) begin
        if (data_fire) begin
            a_shift_reg <= {s_fetched_word[7:0], s_fetched_word[15:8]};
            a_depth_reg <= depth_reg;
            a_left_reg  <= load_left;
            a_pass_reg  <= load_pass;
            a_last_reg  <= last_word;
        end else if (issue) begin
            a_shift_reg <= shift_adv;
            a_left_reg  <= a_left_reg - lpu_pkg::LEFT_W'(1);
        end
    end

    lpu_ram #(
        .WIDTH (16),
        .DEPTH (lpu_pkg::PALETTE_ENTRIES)
    ) u_palette (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Read stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (issue) begin
            b_valid_reg <= 1'b1;
        end else if (b_move) begin
            b_valid_reg <= 1'b0;
        end
    end

    // Read stage payload, travels beside the memory read
    always_ff @(posedge aclk) begin
        if (issue) begin
            b_pass_reg <= a_pass_reg;
            b_word_reg <= {a_shift_reg[7:0], a_shift_reg[15:8]};
            b_ok_reg   <= rd_in_range && pal_ok_reg[ram_raddr];
            b_low_reg  <= (a_left_reg == '0);
            b_done_reg <= a_last_reg && (a_left_reg == '0);
        end
    end

    // Output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (b_move) begin
            c_valid_reg <= 1'b1;
        end else if (m_ready) begin
            c_valid_reg <= 1'b0;
        end
    end

    // Output register payload; unwritten entries read as zero
    always_ff @(posedge aclk) begin
        if (b_move) begin
            c_pixel_reg <= b_pass_reg ? b_word_reg : (b_ok_reg ? ram_rdata : 16'h0000);
            c_low_reg   <= b_low_reg;
            c_done_reg  <= b_done_reg;
        end
    end

    assign m_valid        = c_valid_reg;
    assign m_pixel        = c_pixel_reg;
    assign m_last_of_word = c_low_reg;
    assign m_frame_done   = c_done_reg;

    // The frame ends only on the last pixel of a word
    a_done_has_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_frame_done || m_last_of_word))
        else $error("frame end flagged on a pixel that does not end its word");

    // A held unpack stage keeps its pixel position
    a_hold_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !issue) |=> ($stable(a_left_reg) && $stable(a_shift_reg)))
        else $error("unpack stage moved without issuing a read");

    // Pass-through words produce a single pixel
    a_pass_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && a_pass_reg) |-> (a_left_reg == '0))
        else $error("pass-through word scheduled for more than one pixel");

endmodule

@@ tb/tb.sv @@
// Testbench for lcd_palette_pixel_unpacker_unit: streams palette and pixel words
// under random idling, predicts each RGB565 pixel in a scoreboard class and checks it.
// Depends on lpu_pkg and the unit's RTL only.
module tb;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int INPUT_WORDS   = 100;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_FRAME     = 16;

    // Register write masks, one bit per register index
    localparam bit [3:0] W_MODE = 4'b1 << lpu_pkg::CFG_DATA_ONLY;
    localparam bit [3:0] W_MONO = 4'b1 << lpu_pkg::CFG_MONO;
    localparam bit [3:0] W_SIZE = (4'b1 << lpu_pkg::CFG_WIDTH) | (4'b1 << lpu_pkg::CFG_HEIGHT);
    localparam bit [3:0] W_ALL  = W_MODE | W_MONO | W_SIZE;

    // Tracks frame sequencing and the palette, holds expected pixels in order
    class unpack_scoreboard;
        localparam int REPORT_MAX = 10;
        localparam int PAL_SIZE   = 256;
        localparam int MAX_SIDE   = 1024;

        typedef struct packed {
            logic [15:0] pixel;
            logic        last_of_word;
            logic        frame_done;
        } pixel_t;

        pixel_t          expected_pixels[$];
        bit [4:0]        grey5[16];
        bit [5:0]        grey6[16];
        bit [4:0]        ramp5[16];
        bit [5:0]        ramp6[16];
        bit [15:0]       colors[PAL_SIZE];
        bit              data_only;
        bit              mono;
        bit [9:0]        width_m1;
        bit [9:0]        height_m1;
        lpu_pkg::phase_t phase;
        bit [8:0]        pal_count;
        bit [8:0]        pal_len;
        bit [2:0]        depth;
        bit [20:0]       word_count;
        int              errors;

        function new();
            grey6 = '{63, 58, 54, 49, 45, 40, 36, 31, 27, 22, 18, 13, 9, 4, 0, 0};
            grey5 = '{31, 29, 27, 24, 22, 20, 18, 15, 13, 11, 9, 7, 4, 2, 0, 0};
            ramp6 = '{0, 4, 8, 13, 17, 21, 25, 29, 34, 38, 42, 46, 50, 55, 59, 63};
            ramp5 = '{0, 2, 4, 6, 8, 10, 12, 14, 17, 19, 21, 23, 25, 27, 29, 31};
            errors    = 0;
            data_only = 1'b0;
            mono      = 1'b0;
            width_m1  = '0;
            height_m1 = '0;
            pal_len   = 9'd16;
            depth     = lpu_pkg::DEPTH_1BPP;
            foreach (colors[i]) colors[i] = '0;
            open_frame();
        endfunction

        function void open_frame();
            phase      = data_only ? lpu_pkg::PH_DATA : lpu_pkg::PH_PALETTE;
            pal_count  = '0;
            word_count = '0;
        endfunction

        // Widen a palette word to RGB565 with the current mono setting
        function bit [15:0] widen(bit [15:0] v);
            if (mono) return {grey5[v[3:0]], grey6[v[3:0]], grey5[v[3:0]]};
            return {ramp5[v[11:8]], ramp6[v[7:4]], ramp5[v[3:0]]};
        endfunction

        // Data words in one frame for a given depth and size
        function int words_per_frame(bit [2:0] d, bit [9:0] wm1, bit [9:0] hm1);
            int w;
            int h;
            int n;
            w = int'(wm1) + 1;
            h = int'(hm1) + 1;
            if (w > MAX_SIDE) w = MAX_SIDE;
            if (h > MAX_SIDE) h = MAX_SIDE;
            n = w * h;
            if (d <= lpu_pkg::DEPTH_8BPP) n = n >> (4 - int'(d));
            if (n == 0) n = 1;
            return n;
        endfunction

        function void write_reg(bit [1:0] idx, bit [9:0] value);
            bit at_start;
            case (idx)
                lpu_pkg::CFG_DATA_ONLY: begin
                    // a mode change waits for the next frame unless one is just opening
                    at_start = (phase == lpu_pkg::PH_PALETTE) ? (pal_count == 0)
                                                              : (word_count == 0);
                    data_only = value[0];
                    if (at_start) open_frame();
                end
                lpu_pkg::CFG_MONO:   mono = value[0];
                lpu_pkg::CFG_WIDTH:  width_m1 = value;
                lpu_pkg::CFG_HEIGHT: height_m1 = value;
                default: ;
            endcase
        endfunction

        // Accepted input word: update state, queue the pixels it yields
        function void note_word(bit [15:0] word);
            bit [15:0] swapped;
            bit [7:0]  idx;
            bit        frame_end;
            int        bits;
            int        count;
            int        k;
            pixel_t    p;
            if (phase == lpu_pkg::PH_PALETTE) begin
                if (pal_count == 0) begin
                    depth   = word[14:12];
                    pal_len = (depth == lpu_pkg::DEPTH_8BPP) ? 9'(PAL_SIZE) : 9'd16;
                end
                if (pal_count < PAL_SIZE) colors[pal_count[7:0]] = widen(word);
                pal_count = pal_count + 1'b1;
                if (pal_count >= pal_len) begin
                    phase      = lpu_pkg::PH_DATA;
                    pal_count  = '0;
                    word_count = '0;
                end
                return;
            end
            frame_end = (int'(word_count) + 1 >= words_per_frame(depth, width_m1, height_m1));
            if (depth <= lpu_pkg::DEPTH_8BPP) begin
                bits    = 1 << depth;
                count   = 16 / bits;
                swapped = {word[7:0], word[15:8]};
                for (k = 0; k < count; k++) begin
                    if (depth == lpu_pkg::DEPTH_8BPP)
                        idx = (k == 0) ? word[7:0] : word[15:8];
                    else
                        idx = 8'((swapped >> (16 - bits * (k + 1))) & ((1 << bits) - 1));
                    p.pixel        = colors[idx];
                    p.last_of_word = (k == count - 1);
                    p.frame_done   = frame_end && (k == count - 1);
                    expected_pixels.push_back(p);
                end
            end else begin
                // pass-through depth: the word itself is the pixel
                p.pixel        = word;
                p.last_of_word = 1'b1;
                p.frame_done   = frame_end;
                expected_pixels.push_back(p);
            end
            if (frame_end) open_frame();
            else word_count = word_count + 1'b1;
        endfunction

        // Accepted pixel: compare with the oldest expectation
        function void check_pixel(bit [15:0] px, bit last, bit done);
            pixel_t want;
            if (expected_pixels.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected pixel %h last_of_word %0d frame_done %0d",
                             px, last, done);
                return;
            end
            want = expected_pixels.pop_front();
            if (want != {px, last, done}) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("pixel mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                             want.pixel, want.last_of_word, want.frame_done,
                             px, last, done);
            end
        endfunction
    endclass

    logic                            aclk           = 1'b0;
    logic                            aresetn        = 1'b0;
    logic                            s_valid        = 1'b0;
    logic                            s_ready;
    logic [15:0]                     s_fetched_word = '0;
    logic                            m_valid;
    logic                            m_ready        = 1'b0;
    logic [15:0]                     m_pixel;
    logic                            m_last_of_word;
    logic                            m_frame_done;
    logic                            cfg_valid      = 1'b0;
    logic                            cfg_ready;
    logic [lpu_pkg::CFG_IDX_W-1:0]   cfg_index      = lpu_pkg::CFG_DATA_ONLY;
    logic [lpu_pkg::CFG_DATA_W-1:0]  cfg_data       = '0;

    unpack_scoreboard sb;
    bit               gaps_on       = 1'b1;
    bit               mode_deferred = 1'b0;
    int               words_sent    = 0;
    int               cycles        = 0;
    int               frame_no;

    lcd_palette_pixel_unpacker_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_fetched_word (s_fetched_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel        (m_pixel),
        .m_last_of_word (m_last_of_word),
        .m_frame_done   (m_frame_done),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Check each pixel transfer, then stall the result side at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_pixel(m_pixel, m_last_of_word, m_frame_done);
        m_ready <= !gaps_on || ($urandom_range(99) >= 25);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("lcd_palette_pixel_unpacker_unit regression: fail");
            $finish;
        end
    end

    // Offer one word, idling at random first; hold it until the transfer
    task automatic send_word(input bit [15:0] word);
        while (gaps_on && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_fetched_word <= word;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(word);
        words_sent++;
    endtask

    // Drop valid, wait for every expected pixel, then let the pipeline empty
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input bit [1:0] idx, input bit [9:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, value);
    endtask

    // Write the masked registers once the block is idle
    task automatic write_regs(input bit [3:0] which, input bit mode, input bit grey,
                              input bit [9:0] wm1, input bit [9:0] hm1);
        drain();
        if (which[lpu_pkg::CFG_DATA_ONLY]) put_reg(lpu_pkg::CFG_DATA_ONLY, 10'(mode));
        if (which[lpu_pkg::CFG_MONO])      put_reg(lpu_pkg::CFG_MONO, 10'(grey));
        if (which[lpu_pkg::CFG_WIDTH])     put_reg(lpu_pkg::CFG_WIDTH, wm1);
        if (which[lpu_pkg::CFG_HEIGHT])    put_reg(lpu_pkg::CFG_HEIGHT, hm1);
        cfg_valid <= 1'b0;
    endtask

    // One random frame: settings, palette if any, then data words to the frame end
    task automatic run_frame(input int nth);
        bit [2:0]  d;
        bit [2:0]  fd;
        bit [9:0]  wm1;
        bit [9:0]  hm1;
        bit        mode;
        bit [15:0] w;
        gaps_on <= !(nth >= 1 && nth < 3);
        d    = (nth < 4) ? 3'(nth) : 3'($urandom_range(7));
        // a full 8 bpp palette alone is longer than the whole run
        if (d == lpu_pkg::DEPTH_8BPP) d = 3'd4 + 3'($urandom_range(3));
        mode = mode_deferred ? sb.data_only : ($urandom_range(3) == 0);
        fd   = mode ? sb.depth : d;
        do begin
            wm1 = ($urandom_range(7) == 0) ? 10'($urandom_range(1023))
                                           : 10'($urandom_range(31));
            hm1 = 10'($urandom_range(3));
        end while (sb.words_per_frame(fd, wm1, hm1) > MAX_FRAME);

        // a deferred mode change must show on this frame, so leave data_only alone
        if (mode_deferred) begin
            mode_deferred = 1'b0;
            write_regs(W_MONO | W_SIZE, mode, 1'($urandom), wm1, hm1);
        end else begin
            write_regs(W_ALL, mode, 1'($urandom), wm1, hm1);
        end

        if (sb.phase == lpu_pkg::PH_PALETTE) begin
            w        = 16'($urandom);
            w[14:12] = d;
            send_word(w);
            while (sb.phase == lpu_pkg::PH_PALETTE) begin
                // flip mono partway through the palette
                if (sb.pal_count == 9'd8 && $urandom_range(3) == 0)
                    write_regs(W_MONO, sb.data_only, !sb.mono, sb.width_m1, sb.height_m1);
                send_word(16'($urandom));
            end
        end

        do begin
            if (sb.word_count == 21'd1 && $urandom_range(4) == 0) begin
                // shrink the screen mid-frame
                write_regs(W_SIZE, sb.data_only, sb.mono, 10'($urandom_range(3)), '0);
            end else if (sb.word_count == 21'd1 && $urandom_range(4) == 0) begin
                write_regs(W_MODE, !sb.data_only, sb.mono, sb.width_m1, sb.height_m1);
                mode_deferred = 1'b1;
            end
            send_word(16'($urandom));
        end while (sb.word_count != 0);
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Data-only straight after reset: depth 1 bpp, palette still zero, one-word frame
        write_regs(W_ALL, 1'b1, 1'b0, '0, '0);
        send_word(16'hffff);

        // Back to palette frames, mono palette, largest screen, 4 bpp
        write_regs(W_ALL, 1'b0, 1'b1, 10'd1023, 10'd1023);
        send_word(16'ha000);
        for (int i = 1; i < 16; i++) send_word(16'(16'h1111 * i));
        send_word(16'h0000);
        send_word(16'hffff);
        send_word(16'h5a3c);

        // Mode change mid-frame waits; shrinking the screen ends the frame on the next word
        write_regs(W_MODE | W_SIZE, 1'b1, 1'b1, 10'd3, '0);
        send_word(16'h3ca5);
        // now data-only, with the 4 bpp depth kept
        send_word(16'h8001);

        frame_no = 0;
        while (words_sent < INPUT_WORDS) begin
            run_frame(frame_no);
            frame_no++;
        end

        drain();
        if (sb.errors == 0 && sb.expected_pixels.size() == 0)
            $display("lcd_palette_pixel_unpacker_unit regression: pass");
        else
            $display("lcd_palette_pixel_unpacker_unit regression: fail");
        $finish;
    end

endmodule

@@ lcd_palette_pixel_unpacker_unit.f @@
hdl/lpu_pkg.sv
hdl/lpu_ram.sv
hdl/lcd_palette_pixel_unpacker_unit.sv
tb/tb.sv
